>>> hdl/swm_pkg.sv
// Shared constants and types for the sliding window median unit.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CNT_W        = 5;
    localparam int AGE_W        = 4;
    localparam int IDX_W        = CNT_W - 1;

    localparam logic [CNT_W-1:0] RESET_LENGTH = CNT_W'(MAX_WINDOW);

    typedef struct packed {
        logic                    vld;
        logic [AGE_W-1:0]        age;
        logic [SAMPLE_WIDTH-1:0] val;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic step;
        logic full;
    } t_cell_ctrl;

endpackage

>>> hdl/swm_cell.sv
// One slot of the sorted sample chain: holds a value and its age, drops and shifts in place.
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctrl              i_ctrl,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [AGE_W-1:0]        i_oldest_age,
    input  t_entry                  i_right_raw,
    input  logic                    i_right_gt,
    input  logic                    i_left_rem,
    input  logic                    i_left_gt_c,
    input  t_entry                  i_left_comp,
    output t_entry                  o_raw,
    output logic                    o_gt,
    output logic                    o_rem,
    output logic                    o_gt_c,
    output t_entry                  o_comp
);

    logic                    r_vld;
    logic [AGE_W-1:0]        r_age;
    logic [SAMPLE_WIDTH-1:0] r_val;
    t_entry                  n_entry;
    logic                    w_del;

    assign o_raw = '{vld: r_vld, age: r_age, val: r_val};
    assign o_gt  = !r_vld || (r_val > i_sample);
    assign w_del = i_ctrl.full && r_vld && (r_age == i_oldest_age);
    assign o_rem = i_left_rem || w_del;

    // close the gap left by the dropped entry
    assign o_comp = o_rem ? i_right_raw : o_raw;
    assign o_gt_c = o_rem ? i_right_gt  : o_gt;

    always_comb begin
        if (o_gt_c && i_left_gt_c) begin
            n_entry = i_left_comp;
        end else if (o_gt_c) begin
            n_entry = '{vld: 1'b1, age: '0, val: i_sample};
        end else begin
            n_entry = o_comp;
        end
        if (!(o_gt_c && !i_left_gt_c)) begin
            n_entry.age = n_entry.age + AGE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctrl.step) begin
            r_vld <= n_entry.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            r_age <= n_entry.age;
            r_val <= n_entry.val;
        end
    end

endmodule

>>> hdl/sliding_window_median_unit.sv
// Sliding window median unit: sorted cell chain with aged entries and a result register.
// An accepted sample is held pending (r_pend) until the result register (r_median, r_out_vld) is free, then loaded.
// Throughput: one sample per cycle while results are taken; the chain updates in a single step per sample.
// A stalled result blocks the chain once one further sample has been taken.
// Reset (synchronous, active low) empties the window and sets the length to 16.
// Writing the window length empties the window and restarts the fill count.
`timescale 1ns / 1ps

module sliding_window_median_unit
    import swm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_sample_valid,
    output logic                    o_sample_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                    o_result_valid,
    input  logic                    i_result_ready,
    output logic [SAMPLE_WIDTH-1:0] o_median,
    output logic [CNT_W-1:0]        o_valid_count,
    input  logic                    i_window_length_we,
    input  logic [CNT_W-1:0]        i_window_length
);

    logic [CNT_W-1:0]        r_len;
    logic [CNT_W-1:0]        n_len;
    logic [CNT_W-1:0]        r_count;
    logic                    r_pend;
    logic                    r_out_vld;
    logic [SAMPLE_WIDTH-1:0] r_median;
    logic [CNT_W-1:0]        r_out_count;

    logic       w_accept;
    logic       w_load;
    logic       w_full;
    t_cell_ctrl w_ctrl;
    logic [AGE_W-1:0] w_oldest_age;

    t_entry w_raw  [MAX_WINDOW];
    t_entry w_comp [MAX_WINDOW];
    logic   w_gt   [MAX_WINDOW];
    logic   w_rem  [MAX_WINDOW];
    logic   w_gt_c [MAX_WINDOW];

    assign w_load         = r_pend && (!r_out_vld || i_result_ready);
    assign o_sample_ready = !r_pend || w_load;
    assign w_accept       = i_sample_valid && o_sample_ready;
    assign w_full         = (r_count == r_len);
    assign w_oldest_age   = AGE_W'(r_len - CNT_W'(1));
    assign w_ctrl         = '{clear: i_window_length_we, step: w_accept, full: w_full};

    always_comb begin
        if (i_window_length == '0) begin
            n_len = CNT_W'(1);
        end else if (i_window_length > CNT_W'(MAX_WINDOW)) begin
            n_len = CNT_W'(MAX_WINDOW);
        end else begin
            n_len = i_window_length;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            t_entry w_right_raw;
            logic   w_right_gt;
            logic   w_left_rem;
            logic   w_left_gt_c;
            t_entry w_left_comp;

            if (g == MAX_WINDOW - 1) begin : g_last
                assign w_right_raw = '{vld: 1'b0, age: '0, val: '0};
                assign w_right_gt  = 1'b1;
            end else begin : g_mid
                assign w_right_raw = w_raw[g+1];
                assign w_right_gt  = w_gt[g+1];
            end

            if (g == 0) begin : g_first
                assign w_left_rem  = 1'b0;
                assign w_left_gt_c = 1'b0;
                assign w_left_comp = '{vld: 1'b0, age: '0, val: '0};
            end else begin : g_rest
                assign w_left_rem  = w_rem[g-1];
                assign w_left_gt_c = w_gt_c[g-1];
                assign w_left_comp = w_comp[g-1];
            end

            swm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_sample     (i_sample),
                .i_oldest_age (w_oldest_age),
                .i_right_raw  (w_right_raw),
                .i_right_gt   (w_right_gt),
                .i_left_rem   (w_left_rem),
                .i_left_gt_c  (w_left_gt_c),
                .i_left_comp  (w_left_comp),
                .o_raw        (w_raw[g]),
                .o_gt         (w_gt[g]),
                .o_rem        (w_rem[g]),
                .o_gt_c       (w_gt_c[g]),
                .o_comp       (w_comp[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= RESET_LENGTH;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_window_length_we) begin
                r_len   <= n_len;
                r_count <= '0;
            end else if (w_accept && !w_full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_result_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_median    <= w_raw[r_count[CNT_W-1:1]].val;
            r_out_count <= r_count;
        end
    end

    assign o_result_valid = r_out_vld;
    assign o_median       = r_median;
    assign o_valid_count  = r_out_count;

endmodule
